/* design/rfe_pkg.sv */
// Shared types and constants for the relief emboss filter.
package rfe_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 16;
	localparam int CHAN_W     = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int WIN_DEPTH  = 8;
	localparam int WIN_IDX_W  = 3;
	localparam int DIFF_W     = 10;

	localparam int BIAS    = 128;
	localparam int SAT_MAX = 255;

	localparam int RESET_WIDTH    = 640;
	localparam int RESET_HEIGHT   = 480;
	localparam int RESET_CHANNELS = 3;
	localparam int MIN_WIDTH      = 3;
	localparam int MIN_HEIGHT     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                has_val;
		logic                compute;
		logic [CHAN_W-1:0]   tail_n;
		logic                eof;
	} rfe_item_t;

endpackage

/* design/rfe_ram.sv */
// Generic simple dual-port RAM, registered read, read-first on a same-address write.
module rfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/rfe_front.sv */
// Config registers, row and byte counters, recent-byte window and line store addressing.
module rfe_front import rfe_pkg::*; #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [SAMPLE_W-1:0]   sample,
	output rfe_item_t             item,
	output logic                  ram_en,
	output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] ram_addr,
	output logic [SAMPLE_W-1:0]   ram_wdata
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int BW = $clog2(STORE_DEPTH + 1);
	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int RST_W = (MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_C = (MAX_CHANNELS < RESET_CHANNELS) ? MAX_CHANNELS : RESET_CHANNELS;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       chan_q;
	logic [AW-1:0]       byte_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [SAMPLE_W-1:0] win_q [WIN_DEPTH];

	logic [WIDTH_W+CW-1:0] rs_full;
	logic [BW-1:0]         row_bytes;
	logic [CW:0]           two_c;
	logic [WIN_IDX_W-1:0]  win_sel;
	logic                  past_c;
	logic                  past_2c;
	logic                  last_byte;
	logic                  row_last;
	logic                  edge_row;
	logic [HEIGHT_W:0]     row_inc;
	logic [WIDTH_W-1:0]    w_sat;
	logic [HEIGHT_W-1:0]   h_sat;
	logic [CHAN_W-1:0]     c_sat;

	assign rs_full   = width_q * chan_q;
	assign row_bytes = BW'(rs_full);
	assign two_c     = {chan_q, 1'b0};
	assign win_sel   = WIN_IDX_W'(two_c - (CW+1)'(1));
	assign past_c    = byte_q >= AW'(chan_q);
	assign past_2c   = byte_q >= AW'(two_c);
	assign last_byte = (BW'(byte_q) + BW'(1)) == row_bytes;
	assign row_inc   = {1'b0, row_q} + (HEIGHT_W+1)'(1);
	assign row_last  = row_inc >= {1'b0, height_q};
	assign edge_row  = (row_q == '0) || row_last;

	assign item.sample  = sample;
	assign item.has_val = past_c;
	assign item.compute = !edge_row && past_2c;
	assign item.tail_n  = last_byte ? CHAN_W'(chan_q) : '0;
	assign item.eof     = last_byte && row_last;

	assign ram_en    = accept && past_2c;
	assign ram_addr  = byte_q - AW'(two_c);
	assign ram_wdata = win_q[win_sel];

	always_comb begin
		w_sat = cfg_data[WIDTH_W-1:0];
		if (w_sat < WIDTH_W'(MIN_WIDTH)) begin
			w_sat = WIDTH_W'(MIN_WIDTH);
		end else if ({2'b00, w_sat} > (WIDTH_W+2)'(MAX_WIDTH)) begin
			w_sat = WIDTH_W'(MAX_WIDTH);
		end
		h_sat = cfg_data[HEIGHT_W-1:0];
		if (h_sat < HEIGHT_W'(MIN_HEIGHT)) begin
			h_sat = HEIGHT_W'(MIN_HEIGHT);
		end
		c_sat = cfg_data[CHAN_W-1:0];
		if (c_sat == '0) begin
			c_sat = CHAN_W'(1);
		end else if (c_sat > CHAN_W'(MAX_CHANNELS)) begin
			c_sat = CHAN_W'(MAX_CHANNELS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(RST_W);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
			chan_q   <= CW'(RST_C);
			byte_q   <= '0;
			row_q    <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= w_sat;
					byte_q  <= '0;
					row_q   <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= h_sat;
					byte_q   <= '0;
					row_q    <= '0;
				end
				REG_CHANNEL_COUNT: begin
					chan_q <= CW'(c_sat);
					byte_q <= '0;
					row_q  <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= sample;
			if (last_byte) begin
				byte_q <= '0;
				row_q  <= row_last ? '0 : row_inc[HEIGHT_W-1:0];
			end else begin
				byte_q <= byte_q + AW'(1);
			end
		end
	end

	a_byte_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		BW'(byte_q) < row_bytes)
		else $error("byte index past end of row");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < height_q)
		else $error("row index past end of frame");

endmodule

/* design/rfe_back.sv */
// Difference and clamp stage, then output register that plays out each row's zero tail.
module rfe_back import rfe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  rfe_item_t           item,
	input  logic [SAMPLE_W-1:0] ram_rdata,
	output logic                hold,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [SAMPLE_W-1:0] value,
	output logic                last_in_run,
	output logic                end_of_frame
);

	rfe_item_t           item_s1;
	logic                valid_s1;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                last_q;
	logic                eof_q;
	logic [CHAN_W-1:0]   zeros_q;
	logic                zeof_q;

	logic                out_take;
	logic                out_free;
	logic                s1_go;
	logic [DIFF_W-1:0]   diff;
	logic [SAMPLE_W-1:0] relief;

	assign out_take = out_valid_q && !result_stall;
	assign out_free = !out_valid_q || (out_take && zeros_q == '0);
	assign s1_go    = valid_s1 && (!item_s1.has_val || out_free);
	assign hold     = valid_s1 && !s1_go;

	assign diff = {2'b00, ram_rdata} + DIFF_W'(BIAS) - {2'b00, item_s1.sample};

	always_comb begin
		if (!item_s1.compute || diff[DIFF_W-1]) begin
			relief = '0;
		end else if (diff[DIFF_W-2]) begin
			relief = SAMPLE_W'(SAT_MAX);
		end else begin
			relief = diff[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			value_q     <= '0;
			last_q      <= 1'b0;
			eof_q       <= 1'b0;
			zeros_q     <= '0;
			zeof_q      <= 1'b0;
		end else if (s1_go && item_s1.has_val) begin
			out_valid_q <= 1'b1;
			value_q     <= relief;
			last_q      <= item_s1.tail_n == '0;
			eof_q       <= 1'b0;
			zeros_q     <= item_s1.tail_n;
			zeof_q      <= item_s1.eof;
		end else if (out_take && zeros_q != '0) begin
			value_q <= '0;
			last_q  <= zeros_q == CHAN_W'(1);
			eof_q   <= zeof_q && zeros_q == CHAN_W'(1);
			zeros_q <= zeros_q - CHAN_W'(1);
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign last_in_run  = last_q;
	assign end_of_frame = eof_q;

	a_tail_pending: assert property (@(posedge clk) disable iff (!arst_n)
		zeros_q != '0 |-> out_valid_q && !last_q)
		else $error("zero tail pending behind a final beat");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eof_q |-> last_q && zeros_q == '0)
		else $error("end of frame on a beat that is not the last");

	a_hold_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> valid_s1 && item_s1.has_val && out_valid_q)
		else $error("input held with nothing in the way");

endmodule

/* design/relief_emboss_filter.sv */
// Relief emboss filter top level: line store RAM, front end and output stage.
// Path: an accepted byte is registered in stage 1 together with its line store read, then
// loaded into the output register once that register is free; the receiver takes it from there.
// Throughput: one byte per cycle; a row's last byte also carries channel_count zero beats,
// which go out while the next row's first channel_count bytes (no beat) pass through, so
// input is held only while result_stall holds back the output register.
// Reset: counters to zero, registers to defaults; line store is not cleared, row 0 fills it.
module relief_emboss_filter import rfe_pkg::*; #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [SAMPLE_W-1:0]   value,
	output logic                  last_in_run,
	output logic                  end_of_frame
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW = $clog2(STORE_DEPTH);

	logic                accept;
	rfe_item_t           item;
	logic                ram_en;
	logic [AW-1:0]       ram_addr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [SAMPLE_W-1:0] ram_rdata;

	assign accept = sample_valid && !sample_stall;

	rfe_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.sample    (sample),
		.item      (item),
		.ram_en    (ram_en),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata)
	);

	// same address read and written in one cycle: read-first returns the previous row
	rfe_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_row_store (
		.clk     (clk),
		.wr_en   (ram_en),
		.wr_addr (ram_addr),
		.wr_data (ram_wdata),
		.rd_en   (ram_en),
		.rd_addr (ram_addr),
		.rd_data (ram_rdata)
	);

	rfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.ram_rdata    (ram_rdata),
		.hold         (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.last_in_run  (last_in_run),
		.end_of_frame (end_of_frame)
	);

endmodule
